// ===== design/lfbp_pkg.sv =====
package lfbp_pkg;

  localparam int NUM_BUFFERS_DEF = 4;
  localparam int LINE_LEN_DEF    = 128;

  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int BIDX_W  = 3;
  localparam int OFF_W   = 7;
  localparam int STAT_W  = 3;
  localparam int RIDX_W  = 2;
  localparam int LEN_W   = 8;
  localparam int MASK_W  = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SUB    = 8'h1A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;

  typedef enum logic [FUNC_W-1:0] {
    FN_RX   = 2'd0,
    FN_REL  = 2'd1,
    FN_RD   = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_STORED    = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_FINISHED  = 3'd3,
    ST_DISCARDED = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_READ      = 3'd6,
    ST_BAD_INDEX = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    BS_READY = 3'b001,
    BS_RECV  = 3'b010,
    BS_FIN   = 3'b100
  } bstate_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER = 1'b0,
    CFG_SUB    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    status_t             status;
    logic [RIDX_W-1:0]   idx;
    logic [LEN_W-1:0]    len;
    logic                rd_hit;
    logic [MASK_W-1:0]   mask;
  } res_t;

endpackage

// ===== design/lfbp_if.sv =====
interface lfbp_in_if;
  logic                            valid;
  logic                            ready;
  logic [lfbp_pkg::FUNC_W-1:0]     func;
  logic [lfbp_pkg::BYTE_W-1:0]     rx_byte;
  logic [lfbp_pkg::BIDX_W-1:0]     buffer_index;
  logic [lfbp_pkg::OFF_W-1:0]      byte_offset;

  modport source (output valid, func, rx_byte, buffer_index, byte_offset, input ready);
  modport sink   (input valid, func, rx_byte, buffer_index, byte_offset, output ready);
endinterface

interface lfbp_out_if;
  logic                            valid;
  logic                            ready;
  logic [lfbp_pkg::STAT_W-1:0]     status;
  logic [lfbp_pkg::RIDX_W-1:0]     result_index;
  logic [lfbp_pkg::LEN_W-1:0]      line_length;
  logic [lfbp_pkg::BYTE_W-1:0]     read_byte;
  logic [lfbp_pkg::MASK_W-1:0]     finished_mask;

  modport source (output valid, status, result_index, line_length, read_byte, finished_mask,
                  input ready);
  modport sink   (input valid, status, result_index, line_length, read_byte, finished_mask,
                  output ready);
endinterface

// ===== design/lfbp_ram.sv =====
module lfbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/lfbp_ctrl.sv =====
module lfbp_ctrl #(
  parameter int NUM_BUFFERS = lfbp_pkg::NUM_BUFFERS_DEF,
  parameter int LINE_LEN    = lfbp_pkg::LINE_LEN_DEF,
  localparam int BI_W   = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1,
  localparam int ADDR_W = $clog2(NUM_BUFFERS * LINE_LEN)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lfbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfbp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              accept,
  input  logic [lfbp_pkg::FUNC_W-1:0]       func,
  input  logic [lfbp_pkg::BYTE_W-1:0]       rx_byte,
  input  logic [lfbp_pkg::BIDX_W-1:0]       buffer_index,
  input  logic [lfbp_pkg::OFF_W-1:0]        byte_offset,
  output lfbp_pkg::res_t                    res,
  output logic                              ram_we,
  output logic [ADDR_W-1:0]                 ram_waddr,
  output logic [lfbp_pkg::BYTE_W-1:0]       ram_wdata,
  output logic                              ram_re,
  output logic [ADDR_W-1:0]                 ram_raddr
);

  logic                           filter_en;
  logic                           sub_en;
  lfbp_pkg::bstate_t              bstat [NUM_BUFFERS];
  logic [lfbp_pkg::LEN_W-1:0]     blen  [NUM_BUFFERS];
  logic                           open_valid;
  logic [BI_W-1:0]                open_idx;
  logic [15:0]                    head;

  lfbp_pkg::func_t                fn;
  logic                           claim_found;
  logic [BI_W-1:0]                claim_idx;
  logic                           bi_ok;
  logic [BI_W-1:0]                sel;
  lfbp_pkg::bstate_t              cur_st;
  logic [lfbp_pkg::LEN_W-1:0]     cur_len;
  logic                           term;
  logic                           do_close;
  logic                           drop;
  logic [lfbp_pkg::LEN_W-1:0]     close_len;
  logic [lfbp_pkg::LEN_W-1:0]     len_inc;
  logic                           upd;
  lfbp_pkg::bstate_t              st_sel_next;
  logic [lfbp_pkg::LEN_W-1:0]     len_sel_next;
  logic                           open_valid_next;
  logic [BI_W-1:0]                open_idx_next;
  logic [15:0]                    head_next;
  lfbp_pkg::status_t              status;
  logic                           store;
  logic                           hit;
  logic [NUM_BUFFERS-1:0]         fin_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_en <= 1'b0;
      sub_en    <= 1'b1;
    end else if (cfg_we) begin
      unique case (lfbp_pkg::cfg_idx_t'(cfg_index))
        lfbp_pkg::CFG_FILTER: filter_en <= cfg_data[0];
        lfbp_pkg::CFG_SUB:    sub_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    claim_found = 1'b0;
    claim_idx   = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (bstat[i] == lfbp_pkg::BS_READY) begin
        claim_found = 1'b1;
        claim_idx   = BI_W'(i);
      end
    end
  end

  always_comb begin
    fn       = lfbp_pkg::func_t'(func);
    bi_ok    = int'(buffer_index) < NUM_BUFFERS;
    if (fn == lfbp_pkg::FN_RX) begin
      sel = open_valid ? open_idx : claim_idx;
    end else begin
      sel = bi_ok ? BI_W'(buffer_index) : '0;
    end
    cur_st  = bstat[sel];
    cur_len = blen[sel];
    len_inc = cur_len + 8'd1;
    term    = (rx_byte == lfbp_pkg::CH_CR) || (rx_byte == lfbp_pkg::CH_LF) ||
              (sub_en && (rx_byte == lfbp_pkg::CH_SUB));

    upd             = 1'b0;
    st_sel_next     = cur_st;
    len_sel_next    = cur_len;
    open_valid_next = open_valid;
    open_idx_next   = open_idx;
    head_next       = head;
    status          = lfbp_pkg::ST_IGNORED;
    store           = 1'b0;
    hit             = 1'b0;
    do_close        = 1'b0;
    drop            = 1'b0;
    close_len       = cur_len;
    res.idx         = '0;
    res.len         = '0;

    unique case (fn)
      lfbp_pkg::FN_RX: begin
        if (!open_valid && !claim_found) begin
          status = lfbp_pkg::ST_DROPPED;
        end else begin
          open_valid_next = 1'b1;
          open_idx_next   = sel;
          if (cur_st == lfbp_pkg::BS_RECV && term) begin
            do_close = 1'b1;
          end else if (cur_st == lfbp_pkg::BS_FIN || term) begin
            status = lfbp_pkg::ST_IGNORED;
          end else if (int'(cur_len) >= LINE_LEN) begin
            do_close = 1'b1;
          end else begin
            store = 1'b1;
            upd   = 1'b1;
            if (cur_len == 8'd0) begin
              head_next[7:0] = rx_byte;
            end else if (cur_len == 8'd1) begin
              head_next[15:8] = rx_byte;
            end
            len_sel_next = len_inc;
            st_sel_next  = lfbp_pkg::BS_RECV;
            status       = lfbp_pkg::ST_STORED;
            if (int'(len_inc) >= LINE_LEN) begin
              do_close  = 1'b1;
              close_len = len_inc;
            end
          end
          if (do_close) begin
            upd  = 1'b1;
            drop = filter_en && ((head_next[7:0] == lfbp_pkg::CH_DOLLAR) ||
                   ((close_len >= 8'd2) && (head_next[15:8] == lfbp_pkg::CH_COMMA)));
            open_valid_next = 1'b0;
            if (drop) begin
              len_sel_next = '0;
              st_sel_next  = lfbp_pkg::BS_READY;
              status       = lfbp_pkg::ST_DISCARDED;
            end else begin
              st_sel_next  = lfbp_pkg::BS_FIN;
              status       = lfbp_pkg::ST_FINISHED;
            end
          end
          res.idx = lfbp_pkg::RIDX_W'(sel);
          res.len = len_sel_next;
        end
      end
      lfbp_pkg::FN_REL: begin
        if (bi_ok) begin
          upd          = 1'b1;
          len_sel_next = '0;
          st_sel_next  = lfbp_pkg::BS_READY;
          status       = lfbp_pkg::ST_RELEASED;
          res.idx      = lfbp_pkg::RIDX_W'(sel);
        end else begin
          status = lfbp_pkg::ST_BAD_INDEX;
        end
      end
      lfbp_pkg::FN_RD: begin
        if (bi_ok) begin
          status  = lfbp_pkg::ST_READ;
          hit     = {1'b0, byte_offset} < cur_len;
          res.idx = lfbp_pkg::RIDX_W'(sel);
          res.len = cur_len;
        end else begin
          status = lfbp_pkg::ST_BAD_INDEX;
        end
      end
      default: begin
        status = lfbp_pkg::ST_IGNORED;
      end
    endcase

    for (int i = 0; i < NUM_BUFFERS; i++) begin
      if (upd && (sel == BI_W'(i))) begin
        fin_vec[i] = st_sel_next == lfbp_pkg::BS_FIN;
      end else begin
        fin_vec[i] = bstat[i] == lfbp_pkg::BS_FIN;
      end
    end

    res.status = status;
    res.rd_hit = hit;
    res.mask   = lfbp_pkg::MASK_W'(fin_vec);
  end

  assign ram_we    = accept && store;
  assign ram_waddr = ADDR_W'(int'(sel) * LINE_LEN + int'(cur_len));
  assign ram_wdata = rx_byte;
  assign ram_re    = accept && hit;
  assign ram_raddr = ADDR_W'(int'(sel) * LINE_LEN + int'(byte_offset));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        bstat[i] <= lfbp_pkg::BS_READY;
        blen[i]  <= '0;
      end
      open_valid <= 1'b0;
      open_idx   <= '0;
      head       <= '0;
    end else if (accept) begin
      if (upd) begin
        bstat[sel] <= st_sel_next;
        blen[sel]  <= len_sel_next;
      end
      open_valid <= open_valid_next;
      open_idx   <= open_idx_next;
      head       <= head_next;
    end
  end

endmodule

// ===== design/lfbp_out.sv =====
module lfbp_out (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  lfbp_pkg::res_t               res_in,
  input  logic [lfbp_pkg::BYTE_W-1:0]  ram_q,
  output logic                         in_ready,
  lfbp_out_if.source                   results
);

  logic            s1_valid;
  lfbp_pkg::res_t  s1;
  logic            s1_adv;

  assign s1_adv   = s1_valid && (!results.valid || results.ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  // hold payloads; read data arrives from the store's registered read in the cycle after the beat
  always_ff @(posedge clk) begin
    if (load) begin
      s1 <= res_in;
    end
    if (s1_adv) begin
      results.status        <= s1.status;
      results.result_index  <= s1.idx;
      results.line_length   <= s1.len;
      results.read_byte     <= s1.rd_hit ? ram_q : '0;
      results.finished_mask <= s1.mask;
    end
  end

endmodule

// ===== design/line_framer_buffer_pool_core.sv =====
// channel  | role     | payload
// items    | sink     | func, rx_byte, buffer_index, byte_offset
// results  | source   | status, result_index, line_length, read_byte, finished_mask
// cfg      | write    | cfg_we, cfg_index, cfg_data (no read-back)
//
// One beat per cycle sustained while results are taken; a result passes through the s1 register
// and then the result register, with read data from the registered read of the line store.
// Reset (rst, synchronous) marks every buffer ready and empty and closes any open line;
// the line store itself is not cleared and needs no clearing pass.
// A stalled result holds; two results can wait before items.ready drops.
module line_framer_buffer_pool_core #(
  parameter int NUM_BUFFERS = lfbp_pkg::NUM_BUFFERS_DEF,
  parameter int LINE_LEN    = lfbp_pkg::LINE_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  lfbp_in_if.sink                         items,
  lfbp_out_if.source                      results,
  input  logic                            cfg_we,
  input  logic [lfbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfbp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = NUM_BUFFERS * LINE_LEN;
  localparam int ADDR_W = $clog2(DEPTH);

  logic                          accept;
  logic                          in_ready;
  lfbp_pkg::res_t                res;
  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [lfbp_pkg::BYTE_W-1:0]   ram_wdata;
  logic                          ram_re;
  logic [ADDR_W-1:0]             ram_raddr;
  logic [lfbp_pkg::BYTE_W-1:0]   ram_q;

  assign items.ready = in_ready;
  assign accept      = items.valid && in_ready;

  lfbp_ctrl #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .LINE_LEN    (LINE_LEN)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .func         (items.func),
    .rx_byte      (items.rx_byte),
    .buffer_index (items.buffer_index),
    .byte_offset  (items.byte_offset),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr)
  );

  lfbp_ram #(
    .WIDTH (lfbp_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  lfbp_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .res_in   (res),
    .ram_q    (ram_q),
    .in_ready (in_ready),
    .results  (results)
  );

  a_no_buffer_fields: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.status == lfbp_pkg::ST_DROPPED ||
                      results.status == lfbp_pkg::ST_BAD_INDEX)
    |-> results.result_index == '0 && results.line_length == '0)
    else $error("no-buffer result carries a buffer");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> int'(results.line_length) <= LINE_LEN)
    else $error("line length above buffer size");

  a_read_only_byte: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status != lfbp_pkg::ST_READ |-> results.read_byte == '0)
    else $error("read byte on a non-read result");

  a_stored_len: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status == lfbp_pkg::ST_STORED |-> results.line_length != '0)
    else $error("stored byte with empty line");

endmodule

// ===== bench/tb_line_framer_buffer_pool_core.sv =====
`timescale 1ns / 1ps

module tb_line_framer_buffer_pool_core;

  localparam int NBUF = lfbp_pkg::NUM_BUFFERS_DEF;
  localparam int LLEN = lfbp_pkg::LINE_LEN_DEF;

  typedef logic [lfbp_pkg::BYTE_W-1:0] byte_t;
  typedef logic [lfbp_pkg::BIDX_W-1:0] bidx_t;
  typedef logic [lfbp_pkg::OFF_W-1:0]  off_t;

  typedef struct {
    lfbp_pkg::status_t               status;
    logic [lfbp_pkg::RIDX_W-1:0]     idx;
    logic [lfbp_pkg::LEN_W-1:0]      len;
    logic [lfbp_pkg::BYTE_W-1:0]     rbyte;
    logic [lfbp_pkg::MASK_W-1:0]     mask;
  } line_result_t;

  class line_pool_scoreboard;
    byte_t               store [NBUF*LLEN];
    lfbp_pkg::bstate_t   bstat [NBUF];
    int unsigned         blen [NBUF];
    bit                  open_v;
    int unsigned         open_i;
    logic [15:0]         head;
    bit                  filt;
    bit                  sub;
    line_result_t        pending_q [$];
    int unsigned         errors;
    int unsigned         seen [8];

    function new();
      foreach (bstat[i]) bstat[i] = lfbp_pkg::BS_READY;
      foreach (blen[i]) blen[i] = 0;
      foreach (seen[i]) seen[i] = 0;
      open_v = 1'b0;
      open_i = 0;
      head = '0;
      filt = 1'b0;
      sub = 1'b1;
      errors = 0;
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    function logic [lfbp_pkg::MASK_W-1:0] finished_bits();
      logic [lfbp_pkg::MASK_W-1:0] m;
      m = '0;
      for (int i = 0; i < NBUF && i < lfbp_pkg::MASK_W; i++)
        if (bstat[i] == lfbp_pkg::BS_FIN) m[i] = 1'b1;
      return m;
    endfunction

    function lfbp_pkg::status_t close_line(int unsigned b);
      bit drop;
      drop = 1'b0;
      if (filt) begin
        if (head[7:0] == lfbp_pkg::CH_DOLLAR) drop = 1'b1;
        if (blen[b] >= 2 && head[15:8] == lfbp_pkg::CH_COMMA) drop = 1'b1;
      end
      open_v = 1'b0;
      if (drop) begin
        blen[b] = 0;
        bstat[b] = lfbp_pkg::BS_READY;
        return lfbp_pkg::ST_DISCARDED;
      end
      bstat[b] = lfbp_pkg::BS_FIN;
      return lfbp_pkg::ST_FINISHED;
    endfunction

    function lfbp_pkg::status_t take_byte(byte_t c, output int unsigned b);
      int sel;
      bit term;
      int unsigned len;
      sel = -1;
      b = 0;
      if (!open_v) begin
        for (int i = NBUF - 1; i >= 0; i--)
          if (bstat[i] == lfbp_pkg::BS_READY) sel = i;
        if (sel < 0) return lfbp_pkg::ST_DROPPED;
        open_v = 1'b1;
        open_i = sel;
      end
      b = open_i;
      term = (c == lfbp_pkg::CH_CR) || (c == lfbp_pkg::CH_LF) ||
             (sub && c == lfbp_pkg::CH_SUB);
      if (bstat[b] == lfbp_pkg::BS_RECV && term) return close_line(b);
      if (bstat[b] == lfbp_pkg::BS_FIN || term) return lfbp_pkg::ST_IGNORED;
      len = blen[b];
      if (len >= LLEN) return close_line(b);
      store[b*LLEN + len] = c;
      if (len == 0) head[7:0] = c;
      else if (len == 1) head[15:8] = c;
      len++;
      blen[b] = len;
      bstat[b] = lfbp_pkg::BS_RECV;
      if (len >= LLEN) return close_line(b);
      return lfbp_pkg::ST_STORED;
    endfunction

    function void note_item(lfbp_pkg::func_t f, byte_t c, bidx_t bi, off_t off);
      line_result_t r;
      int unsigned b;
      r.status = lfbp_pkg::ST_IGNORED;
      r.idx = '0;
      r.len = '0;
      r.rbyte = '0;
      case (f) inside
        lfbp_pkg::FN_RX: begin
          r.status = take_byte(c, b);
          if (r.status != lfbp_pkg::ST_DROPPED) begin
            r.idx = b[lfbp_pkg::RIDX_W-1:0];
            r.len = lfbp_pkg::LEN_W'(blen[b]);
          end
        end
        lfbp_pkg::FN_REL, lfbp_pkg::FN_RD: begin
          if (bi >= NBUF) begin
            r.status = lfbp_pkg::ST_BAD_INDEX;
          end else if (f == lfbp_pkg::FN_REL) begin
            blen[bi] = 0;
            bstat[bi] = lfbp_pkg::BS_READY;
            r.status = lfbp_pkg::ST_RELEASED;
            r.idx = bi[lfbp_pkg::RIDX_W-1:0];
          end else begin
            r.status = lfbp_pkg::ST_READ;
            r.idx = bi[lfbp_pkg::RIDX_W-1:0];
            r.len = lfbp_pkg::LEN_W'(blen[bi]);
            if (off < blen[bi] && off < LLEN) r.rbyte = store[bi*LLEN + off];
          end
        end
        default: r.status = lfbp_pkg::ST_IGNORED;
      endcase
      r.mask = finished_bits();
      seen[r.status]++;
      pending_q.push_back(r);
    endfunction

    function void compare(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(logic [lfbp_pkg::STAT_W-1:0] st,
                               logic [lfbp_pkg::RIDX_W-1:0] idx,
                               logic [lfbp_pkg::LEN_W-1:0] len, byte_t rb,
                               logic [lfbp_pkg::MASK_W-1:0] mask);
      line_result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual status %0h idx %0h len %0h",
                 $time, st, idx, len);
        return;
      end
      e = pending_q.pop_front();
      compare("status", 8'(e.status), 8'(st));
      compare("result_index", 8'(e.idx), 8'(idx));
      compare("line_length", e.len, len);
      compare("read_byte", e.rbyte, rb);
      compare("finished_mask", 8'(e.mask), 8'(mask));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [lfbp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lfbp_pkg::CFG_DATA_W-1:0] cfg_data;
  bit calm = 1'b0;
  int unsigned n_items = 0;
  int unsigned n_settings = 0;

  line_pool_scoreboard sb = new();

  lfbp_in_if  items_if();
  lfbp_out_if results_if();

  line_framer_buffer_pool_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_if),
    .results   (results_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) results_if.ready <= 1'b0;
    else results_if.ready <= calm || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    if (!rst && items_if.valid && items_if.ready)
      sb.note_item(lfbp_pkg::func_t'(items_if.func), items_if.rx_byte,
                   items_if.buffer_index, items_if.byte_offset);
    if (!rst && results_if.valid && results_if.ready)
      sb.check_result(results_if.status, results_if.result_index, results_if.line_length,
                      results_if.read_byte, results_if.finished_mask);
  end

  task automatic send_item(lfbp_pkg::func_t f, byte_t c, bidx_t bi, off_t off);
    if (!calm)
      while ($urandom_range(99) < 14) begin
        items_if.valid <= 1'b0;
        @(posedge clk);
      end
    items_if.valid <= 1'b1;
    items_if.func <= f;
    items_if.rx_byte <= c;
    items_if.buffer_index <= bi;
    items_if.byte_offset <= off;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    if (f != lfbp_pkg::FN_NONE) n_items++;
  endtask

  task automatic send_rx(byte_t c);
    send_item(lfbp_pkg::FN_RX, c, bidx_t'($urandom_range(7)), off_t'($urandom_range(127)));
  endtask

  task automatic send_rd(bidx_t bi, off_t off);
    send_item(lfbp_pkg::FN_RD, byte_t'($urandom_range(255)), bi, off);
  endtask

  task automatic send_rel(bidx_t bi);
    send_item(lfbp_pkg::FN_REL, byte_t'($urandom_range(255)), bi,
              off_t'($urandom_range(127)));
  endtask

  // hold off until every result is back, then let the block sit idle
  task automatic drain();
    items_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(bit filt, bit sub);
    cfg_we <= 1'b1;
    cfg_index <= lfbp_pkg::CFG_FILTER;
    cfg_data <= filt;
    @(posedge clk);
    cfg_index <= lfbp_pkg::CFG_SUB;
    cfg_data <= sub;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.filt = filt;
    sb.sub = sub;
    n_settings++;
  endtask

  task automatic send_line();
    int unsigned n;
    int unsigned r;
    byte_t c;
    r = $urandom_range(99);
    if (r < 80) n = $urandom_range(10, 1);
    else if (r < 98) n = $urandom_range(40, 11);
    else n = $urandom_range(LLEN + 2, LLEN - 4);
    for (int unsigned k = 0; k < n; k++) begin
      if (k == 0 && $urandom_range(99) < 20) c = lfbp_pkg::CH_DOLLAR;
      else if (k == 1 && $urandom_range(99) < 20) c = lfbp_pkg::CH_COMMA;
      else if ($urandom_range(99) < 90) c = byte_t'($urandom_range(126, 32));
      else c = byte_t'($urandom_range(255));
      send_rx(c);
    end
    case ($urandom_range(3))
      0: send_rx(lfbp_pkg::CH_CR);
      1: send_rx(lfbp_pkg::CH_LF);
      2: send_rx(lfbp_pkg::CH_SUB);
      default: begin
        send_rx(lfbp_pkg::CH_CR);
        send_rx(lfbp_pkg::CH_LF);
      end
    endcase
  endtask

  task automatic read_burst();
    bidx_t bi;
    off_t off;
    if ($urandom_range(99) < 88) bi = bidx_t'($urandom_range(NBUF - 1));
    else bi = bidx_t'($urandom_range(7, NBUF));
    repeat ($urandom_range(5, 1)) begin
      if (bi < NBUF && sb.blen[bi] != 0 && $urandom_range(99) < 75)
        off = off_t'($urandom_range(sb.blen[bi] - 1));
      else
        off = off_t'($urandom_range(127));
      send_rd(bi, off);
    end
  endtask

  task automatic release_one();
    int sel;
    sel = -1;
    if ($urandom_range(99) < 70)
      for (int i = 0; i < NBUF; i++)
        if (sb.bstat[i] == lfbp_pkg::BS_FIN && (sel < 0 || $urandom_range(1) == 1)) sel = i;
    if (sel < 0) begin
      if ($urandom_range(99) < 85) sel = $urandom_range(NBUF - 1);
      else sel = $urandom_range(7, NBUF);
    end
    send_rel(bidx_t'(sel));
  endtask

  task automatic noise_item();
    case ($urandom_range(3))
      0, 1: send_item(lfbp_pkg::FN_NONE, byte_t'($urandom_range(255)),
                      bidx_t'($urandom_range(7)), off_t'($urandom_range(127)));
      2: send_rx($urandom_range(1) ? lfbp_pkg::CH_CR : lfbp_pkg::CH_LF);
      default: send_item(lfbp_pkg::func_t'($urandom_range(3)), byte_t'($urandom_range(255)),
                         bidx_t'($urandom_range(7)), off_t'($urandom_range(127)));
    endcase
  endtask

  task automatic run_phase(int unsigned goal);
    int unsigned pick;
    int unsigned stop;
    stop = n_items + goal;
    while (n_items < stop) begin
      pick = $urandom_range(99);
      if (pick < 50) send_line();
      else if (pick < 75) read_burst();
      else if (pick < 92) release_one();
      else noise_item();
    end
  endtask

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    items_if.valid = 1'b0;
    items_if.func = lfbp_pkg::FN_NONE;
    items_if.rx_byte = '0;
    items_if.buffer_index = '0;
    items_if.byte_offset = '0;
    cfg_we = 1'b0;
    cfg_index = lfbp_pkg::CFG_FILTER;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no filtering, SUB terminates
    send_rd(3'd0, 7'd0);
    send_rx(lfbp_pkg::CH_CR);
    send_rx(lfbp_pkg::CH_LF);
    send_rx(lfbp_pkg::CH_DOLLAR);
    send_rx(lfbp_pkg::CH_SUB);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(lfbp_pkg::CH_CR);
    send_rd(3'd1, 7'd1);
    send_rd(3'd1, 7'd127);
    send_rel(3'd7);
    send_rd(3'd4, 7'h55);
    send_item(lfbp_pkg::FN_NONE, 8'hFF, 3'h7, 7'h7F);
    send_rel(3'd0);
    drain();

    write_config(1'b1, 1'b0);
    send_rx(lfbp_pkg::CH_DOLLAR);
    send_rx(lfbp_pkg::CH_LF);
    send_rx("a");
    send_rx(lfbp_pkg::CH_COMMA);
    send_rx(lfbp_pkg::CH_CR);
    send_rx("x");
    send_rx(lfbp_pkg::CH_LF);
    send_rx(lfbp_pkg::CH_COMMA);
    send_rx(lfbp_pkg::CH_SUB);
    send_rx(lfbp_pkg::CH_CR);
    send_rx("q");
    send_rel(3'd3);
    send_rx("r");

    run_phase(350);
    drain();
    write_config(1'b1, 1'b1);
    run_phase(350);
    drain();
    write_config(1'b0, 1'b0);
    calm = 1'b1;
    run_phase(350);
    drain();
    calm = 1'b0;
    write_config(1'b0, 1'b1);
    run_phase(350);

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d results never arrived", $time, sb.pending());
    $display("Run covered %0d beats over %0d register settings: %0d lines finished, %0d %s",
             n_items, n_settings + 1, sb.seen[lfbp_pkg::ST_FINISHED],
             sb.seen[lfbp_pkg::ST_DISCARDED], "discarded.");
    $display("Also %0d bytes dropped with every buffer taken, %0d reads, %0d bad indexes.",
             sb.seen[lfbp_pkg::ST_DROPPED], sb.seen[lfbp_pkg::ST_READ],
             sb.seen[lfbp_pkg::ST_BAD_INDEX]);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== line_framer_buffer_pool_core.f =====
design/lfbp_pkg.sv
design/lfbp_if.sv
design/lfbp_ram.sv
design/lfbp_ctrl.sv
design/lfbp_out.sv
design/line_framer_buffer_pool_core.sv
bench/tb_line_framer_buffer_pool_core.sv
